[sv/group_load_level_hysteresis_macros.svh]
// Assertion helpers for the group load level block.
`ifndef GROUP_LOAD_LEVEL_HYSTERESIS_MACROS_SVH
`define GROUP_LOAD_LEVEL_HYSTERESIS_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define GLH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define GLH_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/glh_pkg.sv]
// ----------------------------------------------------------------------------
// glh_pkg
// Shared types, register indexes and helpers for the group load level block.
// ----------------------------------------------------------------------------
`default_nettype none

package glh_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned LEVEL_W = 2;
   localparam int unsigned INDEX_W = 3;

   localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

   typedef logic [LEVEL_W-1:0] level_type;

   localparam level_type LEVEL_OFF = 2'd0;
   localparam level_type LEVEL_ONE = 2'd1;
   localparam level_type LEVEL_TWO = 2'd2;

   typedef enum logic [INDEX_W-1:0] {
      REG_ENABLED   = 3'd0,
      REG_UP_L1     = 3'd1,
      REG_UP_L2     = 3'd2,
      REG_DOWN_L1   = 3'd3,
      REG_DOWN_L2   = 3'd4,
      REG_UPDATE_PD = 3'd5,
      REG_RETAIN_PD = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic              enabled;
      logic [DATA_W-1:0] up_l1;
      logic [DATA_W-1:0] up_l2;
      logic [DATA_W-1:0] down_l1;
      logic [DATA_W-1:0] down_l2;
      logic [DATA_W-1:0] update_pd;
      logic [DATA_W-1:0] retain_pd;
      logic              active;      // some set up threshold is nonzero
      logic              clear_state; // up threshold write left block inactive
   } cfg_type;

   // Largest set up threshold is nonzero iff any set one is nonzero.
   function automatic logic block_active(input logic [DATA_W-1:0] up1,
                                         input logic [DATA_W-1:0] up2);
      logic a1;
      logic a2;
      a1 = (up1 != ALL_ONES) && (up1 != '0);
      a2 = (up2 != ALL_ONES) && (up2 != '0);
      return a1 || a2;
   endfunction

endpackage

`default_nettype wire

[sv/glh_csr.sv]
// ----------------------------------------------------------------------------
// glh_csr
// Configuration registers; flags a state clear when a threshold write
// leaves the block inactive.
// ----------------------------------------------------------------------------
`default_nettype none

module glh_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [glh_pkg::INDEX_W-1:0]   wr_index,
   input  wire logic [glh_pkg::DATA_W-1:0]    wr_data,
   output glh_pkg::cfg_type                   cfg
);

   logic                       enabled_ff,   enabled_in;
   logic [glh_pkg::DATA_W-1:0] up_l1_ff,     up_l1_in;
   logic [glh_pkg::DATA_W-1:0] up_l2_ff,     up_l2_in;
   logic [glh_pkg::DATA_W-1:0] down_l1_ff,   down_l1_in;
   logic [glh_pkg::DATA_W-1:0] down_l2_ff,   down_l2_in;
   logic [glh_pkg::DATA_W-1:0] update_pd_ff, update_pd_in;
   logic [glh_pkg::DATA_W-1:0] retain_pd_ff, retain_pd_in;
   logic                       up_write;

   always_comb begin
      enabled_in   = enabled_ff;
      up_l1_in     = up_l1_ff;
      up_l2_in     = up_l2_ff;
      down_l1_in   = down_l1_ff;
      down_l2_in   = down_l2_ff;
      update_pd_in = update_pd_ff;
      retain_pd_in = retain_pd_ff;
      up_write     = 1'b0;
      if (wr_en) begin
         case (glh_pkg::reg_index_type'(wr_index))
            glh_pkg::REG_ENABLED: begin
               enabled_in = wr_data[0];
            end
            glh_pkg::REG_UP_L1: begin
               up_l1_in = wr_data;
               up_write = 1'b1;
            end
            glh_pkg::REG_UP_L2: begin
               up_l2_in = wr_data;
               up_write = 1'b1;
            end
            glh_pkg::REG_DOWN_L1: begin
               down_l1_in = wr_data;
            end
            glh_pkg::REG_DOWN_L2: begin
               down_l2_in = wr_data;
            end
            glh_pkg::REG_UPDATE_PD: begin
               update_pd_in = wr_data;
            end
            glh_pkg::REG_RETAIN_PD: begin
               retain_pd_in = wr_data;
            end
            default: begin
               // unknown index: ignored
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         up_l1_ff     <= glh_pkg::ALL_ONES;
         up_l2_ff     <= glh_pkg::ALL_ONES;
         down_l1_ff   <= glh_pkg::ALL_ONES;
         down_l2_ff   <= glh_pkg::ALL_ONES;
         update_pd_ff <= glh_pkg::ALL_ONES;
         retain_pd_ff <= glh_pkg::ALL_ONES;
      end else begin
         enabled_ff   <= enabled_in;
         up_l1_ff     <= up_l1_in;
         up_l2_ff     <= up_l2_in;
         down_l1_ff   <= down_l1_in;
         down_l2_ff   <= down_l2_in;
         update_pd_ff <= update_pd_in;
         retain_pd_ff <= retain_pd_in;
      end
   end

   always_comb begin
      cfg.enabled     = enabled_ff;
      cfg.up_l1       = up_l1_ff;
      cfg.up_l2       = up_l2_ff;
      cfg.down_l1     = down_l1_ff;
      cfg.down_l2     = down_l2_ff;
      cfg.update_pd   = update_pd_ff;
      cfg.retain_pd   = retain_pd_ff;
      cfg.active      = glh_pkg::block_active(up_l1_ff, up_l2_ff);
      cfg.clear_state = up_write && !glh_pkg::block_active(up_l1_in, up_l2_in);
   end

endmodule

`default_nettype wire

[sv/glh_core.sv]
// ----------------------------------------------------------------------------
// glh_core
// Level state and the per-item hysteresis decision.
// ----------------------------------------------------------------------------
`default_nettype none

module glh_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire glh_pkg::cfg_type              cfg,
   input  wire logic                          item_go,
   input  wire logic [glh_pkg::DATA_W-1:0]    now,
   input  wire logic [glh_pkg::DATA_W-1:0]    load,
   output glh_pkg::level_type                 level,
   output logic                               decided
);

   glh_pkg::level_type         level_ff, level_in;
   logic                       fall_ff, fall_in;
   logic [glh_pkg::DATA_W-1:0] fall_at_ff, fall_at_in;
   logic [glh_pkg::DATA_W-1:0] last_ff, last_in;

   logic [glh_pkg::DATA_W-1:0] since_last;
   logic [glh_pkg::DATA_W-1:0] since_fall;
   logic [glh_pkg::DATA_W-1:0] down_cur;
   glh_pkg::level_type         target;
   glh_pkg::level_type         lower;
   logic                       decide;

   assign since_last = now - last_ff;
   assign since_fall = now - fall_at_ff;
   assign decide     = item_go && cfg.enabled && cfg.active && (since_last >= cfg.update_pd);
   assign down_cur   = (level_ff == glh_pkg::LEVEL_TWO) ? cfg.down_l2 : cfg.down_l1;

   always_comb begin
      target = glh_pkg::LEVEL_OFF;
      if (load > cfg.up_l1) begin
         target = (load > cfg.up_l2) ? glh_pkg::LEVEL_TWO : glh_pkg::LEVEL_ONE;
      end
      lower = glh_pkg::LEVEL_OFF;
      if (level_ff == glh_pkg::LEVEL_TWO && load >= cfg.down_l1) begin
         lower = glh_pkg::LEVEL_ONE;
      end
   end

   always_comb begin
      level_in   = level_ff;
      fall_in    = fall_ff;
      fall_at_in = fall_at_ff;
      last_in    = last_ff;
      if (cfg.clear_state) begin
         level_in = glh_pkg::LEVEL_OFF;
         fall_in  = 1'b0;
      end else if (decide) begin
         last_in = now;
         if (level_ff == glh_pkg::LEVEL_OFF || level_ff <= target) begin
            // rising or holding: take the up-threshold level at once
            level_in = target;
            fall_in  = 1'b0;
         end else if (load < down_cur) begin
            if (!fall_ff) begin
               fall_in    = 1'b1;
               fall_at_in = now;
            end else if (since_fall > cfg.retain_pd) begin
               level_in = lower;
               fall_in  = 1'b0;
            end
         end else begin
            fall_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= glh_pkg::LEVEL_OFF;
         fall_ff  <= 1'b0;
         last_ff  <= '0;
      end else begin
         level_ff <= level_in;
         fall_ff  <= fall_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      fall_at_ff <= fall_at_in;
   end

   assign level   = level_in;
   assign decided = decide;

endmodule

`default_nettype wire

[sv/group_load_level_hysteresis.sv]
// Pipeline: an accepted item passes the input register, then the result
//   register. Throughput: one item per cycle unless rsp_ready stalls;
//   the level state is updated in the same cycle the item moves from the
//   input register to the result register.
// Reset (synchronous): registers return to their reset values, level 0,
//   no fall timer, last decision at time 0, both pipeline registers empty.
// ----------------------------------------------------------------------------
// group_load_level_hysteresis
// Picks a load level 0..2 per tick with up thresholds and a timed fall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "group_load_level_hysteresis_macros.svh"

module group_load_level_hysteresis (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [glh_pkg::DATA_W-1:0]    req_now,
   input  wire logic [glh_pkg::DATA_W-1:0]    req_group_load,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [glh_pkg::LEVEL_W-1:0]        rsp_level,
   output logic                               rsp_decided,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [glh_pkg::INDEX_W-1:0]   csr_index,
   input  wire logic [glh_pkg::DATA_W-1:0]    csr_data
);

   glh_pkg::cfg_type           cfg;
   logic                       in_valid_ff, in_valid_in;
   logic [glh_pkg::DATA_W-1:0] now_ff;
   logic [glh_pkg::DATA_W-1:0] load_ff;
   logic                       out_valid_ff, out_valid_in;
   glh_pkg::level_type         level_ff;
   logic                       decided_ff;
   glh_pkg::level_type         level_in;
   logic                       decided_in;
   logic                       advance;
   logic                       req_take;

   assign csr_ready = 1'b1;

   glh_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // item moves to the result register when that register is free or drains
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   glh_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item_go (advance),
      .now     (now_ff),
      .load    (load_ff),
      .level   (level_in),
      .decided (decided_in)
   );

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         now_ff  <= req_now;
         load_ff <= req_group_load;
      end
      if (advance) begin
         level_ff   <= level_in;
         decided_ff <= decided_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_level   = level_ff;
   assign rsp_decided = decided_ff;

   `GLH_ASSERT(a_no_overwrite, out_valid_ff && !rsp_ready |-> !advance, "result overwritten")
   `GLH_ASSERT(a_level_range, rsp_valid |-> rsp_level != 2'd3, "level out of range")
   `GLH_ASSERT(a_disabled_idle, advance && !cfg.enabled |-> !decided_in, "decision while disabled")
   `GLH_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid && req_ready, "pipeline not empty after reset")

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives ticks and register writes into the group load level block. A
// scoreboard keeps its own copy of the registers and the level state, works
// out the level and decision flag of every accepted tick, and checks each
// result in order. Both channels stall at random, in three idle mixes.
// ----------------------------------------------------------------------------
module testbench;
   import glh_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PHASES      = 3;
   localparam int unsigned SEGMENTS    = 10;
   localparam int unsigned SEG_TICKS   = 57;
   localparam int unsigned TAIL_CYCLES = 8;
   localparam logic [INDEX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct {
      level_type level;
      logic      decided;
   } tick_result_type;

   class level_scoreboard;
      logic              en;
      logic [DATA_W-1:0] up1, up2, dn1, dn2, upd_pd, ret_pd;
      level_type         lvl;
      logic              falling;
      logic [DATA_W-1:0] fall_at;
      logic [DATA_W-1:0] last_at;
      tick_result_type   waiting[$];
      int unsigned       errors;

      function new();
         en      = 1'b0;
         up1     = ALL_ONES;
         up2     = ALL_ONES;
         dn1     = ALL_ONES;
         dn2     = ALL_ONES;
         upd_pd  = ALL_ONES;
         ret_pd  = ALL_ONES;
         lvl     = LEVEL_OFF;
         falling = 1'b0;
         fall_at = '0;
         last_at = '0;
         errors  = 0;
      endfunction

      task report(input string what, input longint unsigned got,
                  input longint unsigned want);
         if (errors < 100)
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
         errors++;
      endtask

      function int unsigned pending();
         return waiting.size();
      endfunction

      // all-ones thresholds are unset; active when the top set one is nonzero
      function logic engaged();
         logic [DATA_W-1:0] top;
         top = '0;
         if (up1 != ALL_ONES && up1 > top) top = up1;
         if (up2 != ALL_ONES && up2 > top) top = up2;
         return top != '0;
      endfunction

      function void stop_fall();
         falling = 1'b0;
         fall_at = '0;
      endfunction

      function void write_reg(input logic [INDEX_W-1:0] idx,
                              input logic [DATA_W-1:0] data);
         case (idx)
            REG_ENABLED:   en     = data[0];
            REG_UP_L1:     up1    = data;
            REG_UP_L2:     up2    = data;
            REG_DOWN_L1:   dn1    = data;
            REG_DOWN_L2:   dn2    = data;
            REG_UPDATE_PD: upd_pd = data;
            REG_RETAIN_PD: ret_pd = data;
            default:       return;
         endcase
         if ((idx == REG_UP_L1 || idx == REG_UP_L2) && !engaged()) begin
            lvl = LEVEL_OFF;
            stop_fall();
         end
      endfunction

      function void pick_level(input logic [DATA_W-1:0] stamp,
                               input logic [DATA_W-1:0] load);
         level_type         target;
         logic [DATA_W-1:0] floor;
         target = LEVEL_OFF;
         if (load > up1) begin
            target = LEVEL_ONE;
            if (load > up2) target = LEVEL_TWO;
         end
         if (lvl == LEVEL_OFF || lvl <= target) begin
            lvl = target;
            stop_fall();
            return;
         end
         floor = (lvl == LEVEL_TWO) ? dn2 : dn1;
         if (load < floor) begin
            if (!falling) begin
               falling = 1'b1;
               fall_at = stamp;
            end else if (DATA_W'(stamp - fall_at) > ret_pd) begin
               lvl = (lvl == LEVEL_TWO && load >= dn1) ? LEVEL_ONE : LEVEL_OFF;
               stop_fall();
            end
         end else begin
            stop_fall();
         end
      endfunction

      function void note_tick(input logic [DATA_W-1:0] stamp,
                              input logic [DATA_W-1:0] load);
         tick_result_type res;
         res.decided = 1'b0;
         if (en && engaged() && DATA_W'(stamp - last_at) >= upd_pd) begin
            pick_level(stamp, load);
            last_at     = stamp;
            res.decided = 1'b1;
         end
         res.level = lvl;
         waiting.push_back(res);
      endfunction

      task check_result(input level_type level, input logic decided);
         tick_result_type want;
         if (waiting.size() == 0) begin
            report("unexpected result level", level, 0);
            return;
         end
         want = waiting.pop_front();
         if (level !== want.level) report("level", level, want.level);
         if (decided !== want.decided) report("decided", decided, want.decided);
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [DATA_W-1:0]    req_now = '0;
   logic [DATA_W-1:0]    req_group_load = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [LEVEL_W-1:0]   rsp_level;
   logic                 rsp_decided;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [INDEX_W-1:0]   csr_index = '0;
   logic [DATA_W-1:0]    csr_data = '0;

   level_scoreboard      sb = new();
   int unsigned          send_idle_pct = 22;
   int unsigned          rsp_idle_pct = 80;
   int unsigned          cycle_count = 0;
   logic [DATA_W-1:0]    stamp = '0;

   group_load_level_hysteresis dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_now        (req_now),
      .req_group_load (req_group_load),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_level      (rsp_level),
      .rsp_decided    (rsp_decided),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_level, rsp_decided);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_tick(input logic [DATA_W-1:0] t, input logic [DATA_W-1:0] load);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_now        = t;
      req_group_load = load;
      req_valid      = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_tick(t, load);
   endtask

   // hold off new ticks until every outstanding result is back
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
      @(negedge clock);
      csr_index = idx;
      csr_data  = data;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] pick_threshold();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 6) return ALL_ONES;
      if (pick < 10) return '0;
      if (pick < 14) return $urandom;
      return $urandom_range(0, 1000);
   endfunction

   function automatic logic [DATA_W-1:0] pick_period(input int unsigned hi);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 5) return ALL_ONES;
      if (pick < 10) return $urandom;
      if (pick < 35) return '0;
      return $urandom_range(1, hi);
   endfunction

   task automatic random_setting();
      logic [DATA_W-1:0] base;
      write_csr(REG_ENABLED, ($urandom_range(99) < 90) ? 32'd1 : 32'd0);
      // mostly an ordered pair so level two stays reachable
      if ($urandom_range(99) < 75) begin
         base = $urandom_range(0, 600);
         write_csr(REG_UP_L1, base);
         write_csr(REG_UP_L2, base + $urandom_range(0, 400));
         write_csr(REG_DOWN_L2, $urandom_range(0, 800));
         write_csr(REG_DOWN_L1, $urandom_range(0, 500));
      end else begin
         write_csr(REG_UP_L2, pick_threshold());
         write_csr(REG_UP_L1, pick_threshold());
         write_csr(REG_DOWN_L1, pick_threshold());
         write_csr(REG_DOWN_L2, pick_threshold());
      end
      write_csr(REG_UPDATE_PD, pick_period(6));
      write_csr(REG_RETAIN_PD, pick_period(12));
      if ($urandom_range(99) < 5) write_csr(REG_UNUSED, $urandom);
   endtask

   task automatic random_tick();
      int unsigned       pick;
      logic [DATA_W-1:0] load;
      pick = $urandom_range(99);
      if (pick < 3) stamp = $urandom;
      else stamp = stamp + $urandom_range(0, 4);
      pick = $urandom_range(99);
      if (pick < 10) load = $urandom;
      else if (pick < 14) load = ALL_ONES;
      else if (pick < 18) load = '0;
      else load = $urandom_range(0, 1100);
      send_tick(stamp, load);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset state: disabled, no thresholds
      send_tick(32'd0, 32'd0);
      send_tick(ALL_ONES, ALL_ONES);
      drain();
      write_csr(REG_UNUSED, 32'd1);
      write_csr(REG_ENABLED, 32'd1);
      send_tick(32'd5, 32'd500);
      drain();
      // a zero up threshold leaves the block inactive
      write_csr(REG_UP_L1, 32'd0);
      send_tick(32'd6, 32'd500);
      drain();
      write_csr(REG_UP_L1, 32'd100);
      write_csr(REG_UP_L2, 32'd200);
      write_csr(REG_DOWN_L1, 32'd50);
      write_csr(REG_DOWN_L2, 32'd150);
      write_csr(REG_UPDATE_PD, 32'd0);
      write_csr(REG_RETAIN_PD, 32'd2);
      send_tick(32'd0, 32'd300);
      // fall timer started at time zero
      send_tick(32'd0, 32'd100);
      send_tick(32'd1, 32'd100);
      send_tick(32'd3, 32'd100);
      send_tick(32'd4, 32'd10);
      send_tick(32'd10, 32'd10);
      send_tick(32'd11, 32'd200);
      send_tick(32'd12, ALL_ONES);
      send_tick(32'd13, 32'd160);
      send_tick(32'd14, 32'd100);
      drain();
      // dropping both up thresholds clears the level
      write_csr(REG_UP_L2, ALL_ONES);
      write_csr(REG_UP_L1, ALL_ONES);
      send_tick(32'd20, 32'd500);
      drain();
      write_csr(REG_UP_L1, 32'd100);
      write_csr(REG_UP_L2, 32'd200);
      write_csr(REG_UPDATE_PD, 32'd5);
      write_csr(REG_RETAIN_PD, ALL_ONES);
      send_tick(32'd100, 32'd300);
      send_tick(32'd103, 32'd0);
      send_tick(32'd105, 32'd0);
      send_tick(ALL_ONES - 1, 32'd0);
      send_tick(32'd3, 32'd0);
      drain();
      write_csr(REG_UPDATE_PD, ALL_ONES);
      write_csr(REG_RETAIN_PD, 32'd0);
      send_tick(32'd4, 32'd0);
      send_tick(32'd2, 32'd0);
      drain();
      write_csr(REG_ENABLED, 32'd0);
      send_tick(32'd50, 32'd500);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 22;
               rsp_idle_pct  = 80;
            end
            1: begin
               send_idle_pct = 80;
               rsp_idle_pct  = 22;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            random_setting();
            stamp = ($urandom_range(99) < 20) ? $urandom : $urandom_range(0, 50);
            for (int k = 0; k < SEG_TICKS; k++) random_tick();
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
